@@ rtl/qvna_pkg.sv @@
// shared types and constants for the quad vertex normal accumulator
`default_nettype none
package qvna_pkg;
    localparam int IDX_W   = 10;
    localparam int COORD_W = 16;
    localparam int NORM_W  = 16;
    localparam int SUM_W   = 40;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_FACE   = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef logic [1:0]                req_type_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
endpackage
`default_nettype wire

@@ rtl/qvna_ifs.sv @@
// request and response channel interfaces
`default_nettype none
interface qvna_req_if
    import qvna_pkg::*;
();
    logic      valid;
    logic      ready;
    req_type_t req_type;
    idx_t      vertex_index;
    coord_t    coord_x;
    coord_t    coord_y;
    coord_t    coord_z;
    idx_t      corner_a;
    idx_t      corner_b;
    idx_t      corner_c;
    idx_t      corner_d;

    modport source (output valid, req_type, vertex_index, coord_x, coord_y, coord_z,
                    corner_a, corner_b, corner_c, corner_d, input ready);
    modport sink   (input valid, req_type, vertex_index, coord_x, coord_y, coord_z,
                    corner_a, corner_b, corner_c, corner_d, output ready);
endinterface

interface qvna_rsp_if
    import qvna_pkg::*;
();
    logic  valid;
    logic  ready;
    norm_t normal_x;
    norm_t normal_y;
    norm_t normal_z;
    logic  zero_length;

    modport source (output valid, normal_x, normal_y, normal_z, zero_length, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, zero_length, output ready);
endinterface
`default_nettype wire

@@ rtl/quad_vertex_normal_accumulator.sv @@
// vertex table, per-vertex normal sums and normal read-out
//
//  channel | dir | payload
//  req     | in  | req_type, vertex_index, coord_x/y/z, corner_a..d
//  rsp     | out | normal_x/y/z (Q1.14), zero_length
//
// one item at a time, set by the shared sum memory port and the serial units:
// vertex write; face (3 vertex reads, 6 products on one multiplier, 4
// read-modify-writes); normal read (0 to 10 shift steps, 3 squares, 31-step root,
// 3 x 15-step divisions), cut short for a zero sum.
// after reset a clearing pass writes zero to all MAX_VERTICES sum entries,
// one a cycle, before the first item is taken.
// a finished read waits in the output register while the next item is taken.
`default_nettype none
module quad_vertex_normal_accumulator
    import qvna_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input wire logic  clk,
    input wire logic  rst_n,
    qvna_req_if.sink  req,
    qvna_rsp_if.source rsp
);
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int VW    = 3 * COORD_W;
    localparam int EW    = COORD_W + 1;
    localparam int PW    = 2 * EW;
    localparam int NW    = PW + 1;
    localparam int SW    = 3 * SUM_W;
    localparam int MW    = 30;
    localparam int QW    = 15;
    localparam int SQW   = 2 * MW + 2;
    localparam int LW    = MW + 1;
    localparam int NUMW  = MW + QW;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_EDGE  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ARD   = 4'd6;
    localparam logic [3:0] S_AWR   = 4'd7;
    localparam logic [3:0] S_RRD   = 4'd8;
    localparam logic [3:0] S_RMAG  = 4'd9;
    localparam logic [3:0] S_RSH   = 4'd10;
    localparam logic [3:0] S_RSQ   = 4'd11;
    localparam logic [3:0] S_ROOT  = 4'd12;
    localparam logic [3:0] S_RDLD  = 4'd13;
    localparam logic [3:0] S_RDIV  = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [4:0]    step_reg, step_next;
    logic [1:0]    comp_reg, comp_next;

    req_type_t     type_reg, type_next;
    idx_t          vi_reg, vi_next;
    coord_t        cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    idx_t          corner_reg [4];
    idx_t          corner_next [4];

    logic [VW-1:0]        pos_reg [3];
    logic [VW-1:0]        pos_next [3];
    logic signed [EW-1:0] u_reg [3];
    logic signed [EW-1:0] u_next [3];
    logic signed [EW-1:0] v_reg [3];
    logic signed [EW-1:0] v_next [3];
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] n_next [3];

    logic                 neg_reg [3];
    logic                 neg_next [3];
    logic [SUM_W-1:0]     mag_reg [3];
    logic [SUM_W-1:0]     mag_next [3];
    logic [2*MW-1:0]      sq_reg, sq_next;
    logic [SQW-1:0]       acc_reg, acc_next;
    logic [SQW-1:0]       rv_reg, rv_next;
    logic [SQW-1:0]       res_reg, res_next;
    logic [SQW-1:0]       bit_reg, bit_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [LW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        nlo_reg, nlo_next;
    logic [QW-1:0]        q_reg, q_next;
    norm_t                nrm_reg [3];
    norm_t                nrm_next [3];
    logic                 zero_reg, zero_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    norm_t                rsp_x_reg, rsp_x_next, rsp_y_reg, rsp_y_next, rsp_z_reg, rsp_z_next;
    logic                 rsp_zero_reg, rsp_zero_next;

    logic                 vram_we;
    logic [AW-1:0]        vram_waddr, vram_raddr;
    logic [VW-1:0]        vram_wdata, vram_rdata;
    logic                 sram_we;
    logic [AW-1:0]        sram_waddr, sram_raddr;
    logic [SW-1:0]        sram_wdata, sram_rdata;

    // combinational helpers
    logic signed [EW-1:0]  mul_a, mul_b;
    logic signed [SUM_W:0] sat_wide [3];
    sum_t                  sat_val [3];
    sum_t                  rd_sum [3];
    logic [SQW-1:0]        root_try;
    logic [NUMW-1:0]       num_w;
    logic [LW:0]           div_try;
    logic [QW-1:0]         q_new;
    logic [1:0]            n_idx;
    logic                  corners_ok;
    logic                  vi_ok;
    logic                  out_free;

    qvna_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    qvna_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_sram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (sram_waddr),
        .wdata (sram_wdata),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.normal_x    = rsp_x_reg;
    assign rsp.normal_y    = rsp_y_reg;
    assign rsp.normal_z    = rsp_z_reg;
    assign rsp.zero_length = rsp_zero_reg;

    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign vi_ok      = (32'(vi_reg) < MAX_VERTICES);
    assign corners_ok = (32'(corner_reg[0]) < MAX_VERTICES) && (32'(corner_reg[1]) < MAX_VERTICES)
                     && (32'(corner_reg[2]) < MAX_VERTICES) && (32'(corner_reg[3]) < MAX_VERTICES);

    // sum word layout: x high, z low
    assign rd_sum[0] = sram_rdata[3*SUM_W-1:2*SUM_W];
    assign rd_sum[1] = sram_rdata[2*SUM_W-1:SUM_W];
    assign rd_sum[2] = sram_rdata[SUM_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sat_wide[i] = {rd_sum[i][SUM_W-1], rd_sum[i]} + (SUM_W+1)'(n_reg[i]);
            if (sat_wide[i][SUM_W] != sat_wide[i][SUM_W-1])
            begin
                sat_val[i] = sat_wide[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                : {1'b0, {(SUM_W-1){1'b1}}};
            end
            else
            begin
                sat_val[i] = sat_wide[i][SUM_W-1:0];
            end
        end
    end

    // cross product operand order: x terms, y terms, z terms
    always_comb
    begin
        case (step_reg[2:0])
            3'd0:    begin mul_a = u_reg[1]; mul_b = v_reg[2]; end
            3'd1:    begin mul_a = u_reg[2]; mul_b = v_reg[1]; end
            3'd2:    begin mul_a = u_reg[2]; mul_b = v_reg[0]; end
            3'd3:    begin mul_a = u_reg[0]; mul_b = v_reg[2]; end
            3'd4:    begin mul_a = u_reg[0]; mul_b = v_reg[1]; end
            default: begin mul_a = u_reg[1]; mul_b = v_reg[0]; end
        endcase
    end

    assign n_idx    = 2'((step_reg - 5'd1) >> 1);
    assign root_try = res_reg + bit_reg;
    assign num_w    = {mag_reg[comp_reg][MW-1:0], {(QW-1){1'b0}}} + NUMW'(len_reg >> 1);
    assign div_try  = {rem_reg, nlo_reg[QW-1]};
    assign q_new    = {q_reg[QW-2:0], (div_try >= {1'b0, len_reg})};

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        step_next      = step_reg;
        comp_next      = comp_reg;
        type_next      = type_reg;
        vi_next        = vi_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        prod_next      = prod_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        rv_next        = rv_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        nlo_next       = nlo_reg;
        q_next         = q_reg;
        zero_next      = zero_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_x_next     = rsp_x_reg;
        rsp_y_next     = rsp_y_reg;
        rsp_z_next     = rsp_z_reg;
        rsp_zero_next  = rsp_zero_reg;
        for (int i = 0; i < 4; i++)
        begin
            corner_next[i] = corner_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            pos_next[i] = pos_reg[i];
            u_next[i]   = u_reg[i];
            v_next[i]   = v_reg[i];
            n_next[i]   = n_reg[i];
            neg_next[i] = neg_reg[i];
            mag_next[i] = mag_reg[i];
            nrm_next[i] = nrm_reg[i];
        end

        vram_we    = 1'b0;
        vram_waddr = AW'(vi_reg);
        vram_wdata = {cx_reg, cy_reg, cz_reg};
        vram_raddr = AW'(corner_reg[step_reg[1:0]]);
        sram_we    = 1'b0;
        sram_waddr = AW'(corner_reg[step_reg[1:0]]);
        sram_wdata = {sat_val[0], sat_val[1], sat_val[2]};
        sram_raddr = AW'(corner_reg[step_reg[1:0]]);

        unique case (state_reg)
            S_CLR:
            begin
                sram_we      = 1'b1;
                sram_waddr   = clr_cnt_reg;
                sram_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(MAX_VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    type_next      = req.req_type;
                    vi_next        = req.vertex_index;
                    cx_next        = req.coord_x;
                    cy_next        = req.coord_y;
                    cz_next        = req.coord_z;
                    corner_next[0] = req.corner_a;
                    corner_next[1] = req.corner_b;
                    corner_next[2] = req.corner_c;
                    corner_next[3] = req.corner_d;
                    state_next     = S_DISP;
                end
            end
            S_DISP:
            begin
                step_next  = '0;
                state_next = S_IDLE;
                case (type_reg)
                    REQ_WRITE:
                    begin
                        if (vi_ok)
                        begin
                            vram_we    = 1'b1;
                            sram_we    = 1'b1;
                            sram_waddr = AW'(vi_reg);
                            sram_wdata = '0;
                        end
                    end
                    REQ_FACE:
                    begin
                        if (corners_ok)
                        begin
                            state_next = S_FRD;
                        end
                    end
                    REQ_READ:
                    begin
                        if (vi_ok)
                        begin
                            state_next = S_RRD;
                        end
                        else
                        begin
                            zero_next  = 1'b1;
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FRD:
            begin
                // read data arrives in the cycle after its address
                if (step_reg != 5'd0)
                begin
                    pos_next[step_reg[1:0] - 2'd1] = vram_rdata;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd3)
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    u_next[i] = EW'($signed(pos_reg[1][VW-1-COORD_W*i -: COORD_W]))
                              - EW'($signed(pos_reg[0][VW-1-COORD_W*i -: COORD_W]));
                    v_next[i] = EW'($signed(pos_reg[2][VW-1-COORD_W*i -: COORD_W]))
                              - EW'($signed(pos_reg[0][VW-1-COORD_W*i -: COORD_W]));
                end
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = mul_a * mul_b;
                if (step_reg != 5'd0)
                begin
                    if (step_reg[0])
                    begin
                        n_next[n_idx] = NW'(prod_reg);
                    end
                    else
                    begin
                        n_next[n_idx] = n_reg[n_idx] - NW'(prod_reg);
                    end
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd6)
                begin
                    step_next  = '0;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                state_next = S_AWR;
            end
            S_AWR:
            begin
                // write lands before the next corner is read, so repeats chain
                sram_we   = 1'b1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd3)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ARD;
                end
            end
            S_RRD:
            begin
                sram_raddr = AW'(vi_reg);
                state_next = S_RMAG;
            end
            S_RMAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = rd_sum[i][SUM_W-1];
                    mag_next[i] = rd_sum[i][SUM_W-1] ? SUM_W'(-rd_sum[i]) : rd_sum[i];
                end
                if (sram_rdata == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = S_RSH;
                end
            end
            S_RSH:
            begin
                if ((mag_reg[0][SUM_W-1:MW] | mag_reg[1][SUM_W-1:MW]
                     | mag_reg[2][SUM_W-1:MW]) != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else
                begin
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = S_RSQ;
                end
            end
            S_RSQ:
            begin
                if (step_reg != 5'd3)
                begin
                    sq_next = mag_reg[step_reg[1:0]][MW-1:0] * mag_reg[step_reg[1:0]][MW-1:0];
                end
                if (step_reg != 5'd0)
                begin
                    acc_next = acc_reg + SQW'(sq_reg);
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd3)
                begin
                    rv_next    = acc_reg + SQW'(sq_reg);
                    res_next   = '0;
                    bit_next   = SQW'(1) << (SQW - 2);
                    step_next  = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                // one result bit per cycle, digit by digit
                if (rv_reg >= root_try)
                begin
                    rv_next  = rv_reg - root_try;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(SQW / 2 - 1))
                begin
                    len_next   = LW'(res_next);
                    comp_next  = '0;
                    state_next = S_RDLD;
                end
            end
            S_RDLD:
            begin
                // quotient fits in QW bits, so the upper part is already below len
                rem_next   = LW'(num_w[NUMW-1:QW]);
                nlo_next   = num_w[QW-1:0];
                q_next     = '0;
                step_next  = '0;
                state_next = S_RDIV;
            end
            S_RDIV:
            begin
                if (div_try >= {1'b0, len_reg})
                begin
                    rem_next = LW'(div_try - {1'b0, len_reg});
                end
                else
                begin
                    rem_next = LW'(div_try);
                end
                nlo_next  = nlo_reg << 1;
                q_next    = q_new;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(QW - 1))
                begin
                    nrm_next[comp_reg] = neg_reg[comp_reg] ? -NORM_W'(q_new) : NORM_W'(q_new);
                    comp_next          = comp_reg + 2'd1;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_RDLD;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_x_next     = zero_reg ? '0 : nrm_reg[0];
                    rsp_y_next     = zero_reg ? '0 : nrm_reg[1];
                    rsp_z_next     = zero_reg ? '0 : nrm_reg[2];
                    rsp_zero_next  = zero_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        comp_reg     <= comp_next;
        type_reg     <= type_next;
        vi_reg       <= vi_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        prod_reg     <= prod_next;
        sq_reg       <= sq_next;
        acc_reg      <= acc_next;
        rv_reg       <= rv_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        nlo_reg      <= nlo_next;
        q_reg        <= q_next;
        zero_reg     <= zero_next;
        rsp_x_reg    <= rsp_x_next;
        rsp_y_reg    <= rsp_y_next;
        rsp_z_reg    <= rsp_z_next;
        rsp_zero_reg <= rsp_zero_next;
        for (int i = 0; i < 4; i++)
        begin
            corner_reg[i] <= corner_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            pos_reg[i] <= pos_next[i];
            u_reg[i]   <= u_next[i];
            v_reg[i]   <= v_next[i];
            n_reg[i]   <= n_next[i];
            neg_reg[i] <= neg_next[i];
            mag_reg[i] <= mag_next[i];
            nrm_reg[i] <= nrm_next[i];
        end
    end
endmodule
`default_nettype wire

@@ rtl/qvna_ram.sv @@
// generic single write port ram with registered read
`default_nettype none
module qvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/qvna_checker.sv @@
// port-level checks on the accumulator and their binding
`default_nettype none
module qvna_checker
    import qvna_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  req_valid,
    input wire logic  req_ready,
    input wire logic  rsp_valid,
    input wire logic  rsp_ready,
    input wire norm_t normal_x,
    input wire norm_t normal_y,
    input wire norm_t normal_z,
    input wire logic  zero_length
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(normal_x) && $stable(normal_y)
                                    && $stable(normal_z) && $stable(zero_length))
        else $error("response payload changed while stalled");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && zero_length |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
        else $error("zero length flag with a non-zero normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> normal_x >= -16384 && normal_x <= 16384 && normal_y >= -16384
                      && normal_y <= 16384 && normal_z >= -16384 && normal_z <= 16384)
        else $error("normal component outside unit range");

    a_no_early_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response raised straight after an item was taken");
endmodule

bind quad_vertex_normal_accumulator qvna_checker u_qvna_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .normal_x    (rsp.normal_x),
    .normal_y    (rsp.normal_y),
    .normal_z    (rsp.normal_z),
    .zero_length (rsp.zero_length)
);
`default_nettype wire
